>>> rtl/core/smas_pkg.sv
// Shared types and constants for the stereo mixer with aux sends.
// No dependencies; every other file in rtl/core imports this package.
package smas_pkg;

   localparam int SMP_W     = 24;
   localparam int GAIN_W    = 17;
   localparam int ACC_W     = 32;
   localparam int TMP_W     = 26;
   localparam int MUL_A_W   = 32;
   localparam int MUL_B_W   = 20;
   localparam int PROD_W    = 53;
   localparam int CSR_IDX_W = 3;

   localparam logic [1:0] CMD_CHANNEL = 2'd0;
   localparam logic [1:0] CMD_RETURN  = 2'd1;
   localparam logic [1:0] CMD_FRAME   = 2'd2;
   localparam logic [1:0] CMD_LOAD    = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_MASTER_GAIN     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RETURN_ONE_GAIN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RETURN_TWO_GAIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SEND_ONE_MASTER = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SEND_TWO_MASTER = 3'd4;

   // floor(cv / 10) = (cv * VOL_RECIP) >> 23, exact for cv below 2^22
   localparam logic [MUL_B_W-1:0]       VOL_RECIP   = 20'd838861;
   localparam int                       VOL_SHIFT   = 23;
   localparam logic [GAIN_W-1:0]        VOL_FULL    = 17'h10000;
   localparam logic signed [SMP_W-1:0]  CV_FULL     = 24'sd655360;
   localparam logic [GAIN_W-1:0]        MASTER_RST  = 17'd32768;

   typedef struct packed {
      logic [1:0]              cmd;
      logic [2:0]              channel;
      logic signed [SMP_W-1:0] left_sample;
      logic signed [SMP_W-1:0] right_sample;
      logic signed [SMP_W-1:0] volume_cv;
      logic                    volume_cv_present;
      logic signed [SMP_W-1:0] mute_cv;
      logic                    mute_button;
      logic [GAIN_W-1:0]       fader_gain;
      logic [GAIN_W-1:0]       aux_one_gain;
      logic [GAIN_W-1:0]       aux_two_gain;
   } req_type;

   typedef struct packed {
      logic signed [SMP_W-1:0] mix_left;
      logic signed [SMP_W-1:0] mix_right;
      logic signed [SMP_W-1:0] send_one_left;
      logic signed [SMP_W-1:0] send_one_right;
      logic signed [SMP_W-1:0] send_two_left;
      logic signed [SMP_W-1:0] send_two_right;
      logic [7:0]              mute_lights;
   } rsp_type;

   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_CHANNEL,
      KIND_RETURN,
      KIND_FRAME,
      KIND_LOAD
   } kind_type;

   typedef enum logic [4:0] {
      STEP_IDLE,
      STEP_VOL,
      STEP_LF,
      STEP_RF,
      STEP_LV,
      STEP_RV,
      STEP_L1,
      STEP_R1,
      STEP_L1V,
      STEP_R1V,
      STEP_L2,
      STEP_R2,
      STEP_L2V,
      STEP_R2V,
      STEP_CH_END,
      STEP_RET_L,
      STEP_RET_R,
      STEP_RET_END,
      STEP_FR_ML,
      STEP_FR_MR,
      STEP_FR_S1L,
      STEP_FR_S1R,
      STEP_FR_S2L,
      STEP_FR_S2R,
      STEP_FR_END
   } step_type;

   typedef struct packed {
      logic     accept;
      step_type step;
   } dp_cmd_type;

   typedef struct packed {
      kind_type kind;
   } dp_status_type;

endpackage

>>> rtl/core/smas_if.sv
// Request and response channel interfaces for the stereo mixer core.
// Depends on smas_pkg for the payload types.
interface smas_req_if;
   import smas_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface smas_rsp_if;
   import smas_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/stereo_mixer_aux_sends_core.sv
// Top level of the stereo mixer with aux sends: sequencer plus datapath.
// Depends on smas_pkg, smas_if, smas_ctrl and smas_datapath.
//
//   channel   dir  handshake              payload
//   req_chan  in   valid/ready            cmd, channel, samples, CVs, gains
//   rsp_chan  out  valid/ready            mix, send one/two, mute_lights
//   csr       in   csr_we, no wait        csr_index, csr_wdata (17 bits)
//
// One 32x20 multiplier is shared by all products, one product per cycle while no step waits.
// Channel, return and end-of-frame items run through their own step sequences; load and ignored items need no steps.
// An end-of-frame item waits on its first step while the previous result is untaken.
// Requests are taken whenever the sequencer is idle, also with a result pending.
// Synchronous reset: unmuted, gain tables, sums zero, master_gain 32768.
module stereo_mixer_aux_sends_core #(
   parameter int CHANNELS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   smas_req_if.sink                       req_chan,
   smas_rsp_if.source                     rsp_chan,
   input  logic                           csr_we,
   input  logic [smas_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [smas_pkg::GAIN_W-1:0]    csr_wdata
);
   import smas_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   smas_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   smas_datapath #(
      .CHANNELS (CHANNELS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (dp_cmd),
      .status    (dp_status),
      .req_data  (req_chan.data),
      .rsp_data  (rsp_chan.data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule

>>> rtl/core/smas_ctrl.sv
// Sequencer for the mixer: request/response handshake and datapath step order.
// Depends on smas_pkg.
module smas_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  smas_pkg::dp_status_type status,
   output smas_pkg::dp_cmd_type    cmd
);
   import smas_pkg::*;

   typedef enum logic {ST_IDLE, ST_BUSY} state_type;

   state_type state_ff, state_in;
   step_type  step_ff, step_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid & req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign cmd.accept = accept;
   assign cmd.step   = step_ff;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (status.kind)
                  KIND_CHANNEL: begin
                     state_in = ST_BUSY;
                     step_in  = STEP_VOL;
                  end
                  KIND_RETURN: begin
                     state_in = ST_BUSY;
                     step_in  = STEP_RET_L;
                  end
                  KIND_FRAME: begin
                     state_in = ST_BUSY;
                     step_in  = STEP_FR_ML;
                  end
                  default: ;
               endcase
            end
         end
         ST_BUSY: begin
            unique case (step_ff)
               STEP_VOL:     step_in = STEP_LF;
               STEP_LF:      step_in = STEP_RF;
               STEP_RF:      step_in = STEP_LV;
               STEP_LV:      step_in = STEP_RV;
               STEP_RV:      step_in = STEP_L1;
               STEP_L1:      step_in = STEP_R1;
               STEP_R1:      step_in = STEP_L1V;
               STEP_L1V:     step_in = STEP_R1V;
               STEP_R1V:     step_in = STEP_L2;
               STEP_L2:      step_in = STEP_R2;
               STEP_R2:      step_in = STEP_L2V;
               STEP_L2V:     step_in = STEP_R2V;
               STEP_R2V:     step_in = STEP_CH_END;
               STEP_RET_L:   step_in = STEP_RET_R;
               STEP_RET_R:   step_in = STEP_RET_END;
               // output registers are rewritten from the next step on
               STEP_FR_ML: begin
                  if (!rsp_valid_ff || rsp_ready) begin
                     step_in = STEP_FR_MR;
                  end
               end
               STEP_FR_MR:   step_in = STEP_FR_S1L;
               STEP_FR_S1L:  step_in = STEP_FR_S1R;
               STEP_FR_S1R:  step_in = STEP_FR_S2L;
               STEP_FR_S2L:  step_in = STEP_FR_S2R;
               STEP_FR_S2R:  step_in = STEP_FR_END;
               STEP_FR_END: begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
                  step_in      = STEP_IDLE;
               end
               default: begin
                  state_in = ST_IDLE;
                  step_in  = STEP_IDLE;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
            step_in  = STEP_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/core/smas_datapath.sv
// Mixer datapath: gain tables, mute state, accumulators, one shared multiplier.
// Depends on smas_pkg; driven step by step from smas_ctrl.
module smas_datapath #(
   parameter int CHANNELS = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  smas_pkg::dp_cmd_type              cmd,
   output smas_pkg::dp_status_type           status,
   input  smas_pkg::req_type                 req_data,
   output smas_pkg::rsp_type                 rsp_data,
   input  logic                             csr_we,
   input  logic [smas_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [smas_pkg::GAIN_W-1:0]      csr_wdata
);
   import smas_pkg::*;

   localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int LIGHTS = (CHANNELS < 8) ? CHANNELS : 8;

   function automatic logic signed [ACC_W-1:0] acc_add(
      input logic signed [ACC_W-1:0] acc,
      input logic signed [TMP_W:0]   v
   );
      logic [ACC_W:0] sum;
      sum = {acc[ACC_W-1], acc} + {{(ACC_W-TMP_W){v[TMP_W]}}, v};
      if (sum[ACC_W] != sum[ACC_W-1]) begin
         acc_add = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         acc_add = sum[ACC_W-1:0];
      end
   endfunction

   function automatic logic signed [SMP_W-1:0] sat24(input logic signed [PROD_W-1:0] x);
      if (x > 53'sd8388607) begin
         sat24 = {1'b0, {(SMP_W-1){1'b1}}};
      end else if (x < -53'sd8388608) begin
         sat24 = {1'b1, {(SMP_W-1){1'b0}}};
      end else begin
         sat24 = x[SMP_W-1:0];
      end
   endfunction

   // configuration
   logic [GAIN_W-1:0] master_gain_ff, ret_one_gain_ff, ret_two_gain_ff;
   logic [GAIN_W-1:0] send_one_master_ff, send_two_master_ff;

   // per-channel state
   logic [CHANNELS-1:0] unmuted_ff;
   logic [CHANNELS-1:0] trig_ff;
   logic [GAIN_W-1:0]   fader_ff [CHANNELS];
   logic [GAIN_W-1:0]   aux_one_ff [CHANNELS];
   logic [GAIN_W-1:0]   aux_two_ff [CHANNELS];
   logic [7:0]          gate_seen_ff;

   logic signed [ACC_W-1:0] acc_ml_ff, acc_mr_ff, acc_s1l_ff, acc_s1r_ff;
   logic signed [ACC_W-1:0] acc_s2l_ff, acc_s2r_ff;

   // latched item and working registers
   logic signed [SMP_W-1:0] left_ff, right_ff, cv_ff;
   logic                    cv_on_ff, zero_ff, ret_two_ff;
   logic [IDX_W-1:0]        idx_ff;
   logic [GAIN_W-1:0]       vol_ff;
   logic signed [TMP_W-1:0] tmp_l_ff, tmp_r_ff, sl_ff, sr_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   rsp_type                 out_ff;

   logic [IDX_W-1:0]          req_idx;
   logic                      ch_ok, gated, unmuted_next;
   logic signed [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0]        mul_b;
   logic signed [MUL_B_W:0]   mul_b_s;
   logic [MUL_B_W-1:0]        g1, g2;
   logic [GAIN_W-1:0]         ret_gain, vol_in;
   logic signed [TMP_W-1:0]   shr16, scaled;
   logic signed [PROD_W-1:0]  shr17;
   logic [7:0]                lights;

   assign req_idx = IDX_W'(req_data.channel);
   assign ch_ok   = 32'(req_data.channel) < CHANNELS;
   assign gated   = req_data.mute_cv > 24'sd0;
   assign unmuted_next = unmuted_ff[req_idx] ^ (req_data.mute_button & ~trig_ff[req_idx]);

   always_comb begin
      unique case (req_data.cmd)
         CMD_CHANNEL: status.kind = ch_ok ? KIND_CHANNEL : KIND_NONE;
         CMD_RETURN:  status.kind = (req_data.channel == 3'd0 || req_data.channel == 3'd1) ?
                                    KIND_RETURN : KIND_NONE;
         CMD_FRAME:   status.kind = KIND_FRAME;
         CMD_LOAD:    status.kind = ch_ok ? KIND_LOAD : KIND_NONE;
      endcase
   end

   assign g1       = {2'b0, send_one_master_ff, 1'b0} + MUL_B_W'(send_one_master_ff);
   assign g2       = {2'b0, send_two_master_ff, 1'b0} + MUL_B_W'(send_two_master_ff);
   assign ret_gain = ret_two_ff ? ret_two_gain_ff : ret_one_gain_ff;
   assign shr16    = prod_ff[TMP_W+15:16];
   assign scaled   = zero_ff ? '0 : shr16;
   assign shr17    = prod_ff >>> 17;

   always_comb begin
      if (!cv_on_ff) begin
         vol_in = VOL_FULL;
      end else if (cv_ff <= 24'sd0) begin
         vol_in = '0;
      end else if (cv_ff >= CV_FULL) begin
         vol_in = VOL_FULL;
      end else begin
         vol_in = prod_ff[VOL_SHIFT+GAIN_W-1:VOL_SHIFT];
      end
   end

   for (genvar g = 0; g < 8; g++) begin : g_light
      if (g < LIGHTS) begin : g_on
         assign lights[g] = unmuted_ff[g] & ~gate_seen_ff[g];
      end else begin : g_off
         assign lights[g] = 1'b0;
      end
   end

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.step)
         STEP_VOL:    begin mul_a = MUL_A_W'(cv_ff);    mul_b = VOL_RECIP; end
         STEP_LF:     begin mul_a = MUL_A_W'(left_ff);  mul_b = MUL_B_W'(fader_ff[idx_ff]); end
         STEP_RF:     begin mul_a = MUL_A_W'(right_ff); mul_b = MUL_B_W'(fader_ff[idx_ff]); end
         STEP_LV,
         STEP_L1V,
         STEP_L2V:    begin mul_a = MUL_A_W'(tmp_l_ff); mul_b = MUL_B_W'(vol_ff); end
         STEP_RV,
         STEP_R1V,
         STEP_R2V:    begin mul_a = MUL_A_W'(tmp_r_ff); mul_b = MUL_B_W'(vol_ff); end
         STEP_L1:     begin mul_a = MUL_A_W'(sl_ff);    mul_b = MUL_B_W'(aux_one_ff[idx_ff]); end
         STEP_R1:     begin mul_a = MUL_A_W'(sr_ff);    mul_b = MUL_B_W'(aux_one_ff[idx_ff]); end
         STEP_L2:     begin mul_a = MUL_A_W'(sl_ff);    mul_b = MUL_B_W'(aux_two_ff[idx_ff]); end
         STEP_R2:     begin mul_a = MUL_A_W'(sr_ff);    mul_b = MUL_B_W'(aux_two_ff[idx_ff]); end
         STEP_RET_L:  begin mul_a = MUL_A_W'(left_ff);  mul_b = MUL_B_W'(ret_gain); end
         STEP_RET_R:  begin mul_a = MUL_A_W'(right_ff); mul_b = MUL_B_W'(ret_gain); end
         STEP_FR_ML:  begin mul_a = acc_ml_ff;  mul_b = MUL_B_W'(master_gain_ff); end
         STEP_FR_MR:  begin mul_a = acc_mr_ff;  mul_b = MUL_B_W'(master_gain_ff); end
         STEP_FR_S1L: begin mul_a = acc_s1l_ff; mul_b = g1; end
         STEP_FR_S1R: begin mul_a = acc_s1r_ff; mul_b = g1; end
         STEP_FR_S2L: begin mul_a = acc_s2l_ff; mul_b = g2; end
         STEP_FR_S2R: begin mul_a = acc_s2r_ff; mul_b = g2; end
         default: ;
      endcase
   end

   assign mul_b_s = $signed({1'b0, mul_b});
   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b_s);

   always_ff @(posedge clock) begin
      if (reset) begin
         master_gain_ff     <= MASTER_RST;
         ret_one_gain_ff    <= '0;
         ret_two_gain_ff    <= '0;
         send_one_master_ff <= '0;
         send_two_master_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MASTER_GAIN:     master_gain_ff     <= csr_wdata;
            CSR_RETURN_ONE_GAIN: ret_one_gain_ff    <= csr_wdata;
            CSR_RETURN_TWO_GAIN: ret_two_gain_ff    <= csr_wdata;
            CSR_SEND_ONE_MASTER: send_one_master_ff <= csr_wdata;
            CSR_SEND_TWO_MASTER: send_two_master_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unmuted_ff   <= '1;
         trig_ff      <= '0;
         gate_seen_ff <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            fader_ff[i]   <= '0;
            aux_one_ff[i] <= '0;
            aux_two_ff[i] <= '0;
         end
         acc_ml_ff  <= '0;
         acc_mr_ff  <= '0;
         acc_s1l_ff <= '0;
         acc_s1r_ff <= '0;
         acc_s2l_ff <= '0;
         acc_s2r_ff <= '0;
      end else begin
         if (cmd.accept && status.kind == KIND_CHANNEL) begin
            unmuted_ff[req_idx] <= unmuted_next;
            trig_ff[req_idx]    <= req_data.mute_button;
            if (gated) begin
               gate_seen_ff[req_data.channel] <= 1'b1;
            end
         end
         if (cmd.accept && status.kind == KIND_LOAD) begin
            fader_ff[req_idx]   <= req_data.fader_gain;
            aux_one_ff[req_idx] <= req_data.aux_one_gain;
            aux_two_ff[req_idx] <= req_data.aux_two_gain;
         end
         unique case (cmd.step)
            STEP_RV:      acc_ml_ff  <= acc_add(acc_ml_ff, {scaled, 1'b0});
            STEP_L1:      acc_mr_ff  <= acc_add(acc_mr_ff, {scaled, 1'b0});
            STEP_R1V:     acc_s1l_ff <= acc_add(acc_s1l_ff, {shr16[TMP_W-1], shr16});
            STEP_L2:      acc_s1r_ff <= acc_add(acc_s1r_ff, {shr16[TMP_W-1], shr16});
            STEP_R2V:     acc_s2l_ff <= acc_add(acc_s2l_ff, {shr16[TMP_W-1], shr16});
            STEP_CH_END:  acc_s2r_ff <= acc_add(acc_s2r_ff, {shr16[TMP_W-1], shr16});
            STEP_RET_R:   acc_ml_ff  <= acc_add(acc_ml_ff, {shr16[TMP_W-1], shr16});
            STEP_RET_END: acc_mr_ff  <= acc_add(acc_mr_ff, {shr16[TMP_W-1], shr16});
            STEP_FR_END: begin
               acc_ml_ff    <= '0;
               acc_mr_ff    <= '0;
               acc_s1l_ff   <= '0;
               acc_s1r_ff   <= '0;
               acc_s2l_ff   <= '0;
               acc_s2r_ff   <= '0;
               gate_seen_ff <= '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (cmd.accept) begin
         left_ff    <= req_data.left_sample;
         right_ff   <= req_data.right_sample;
         cv_ff      <= req_data.volume_cv;
         cv_on_ff   <= req_data.volume_cv_present;
         idx_ff     <= req_idx;
         ret_two_ff <= req_data.channel[0];
         zero_ff    <= ~unmuted_next | gated;
      end
      unique case (cmd.step)
         STEP_LF:     vol_ff   <= vol_in;
         STEP_RF,
         STEP_R1,
         STEP_R2:     tmp_l_ff <= shr16;
         STEP_LV,
         STEP_L1V,
         STEP_L2V:    tmp_r_ff <= shr16;
         STEP_RV:     sl_ff    <= scaled;
         STEP_L1:     sr_ff    <= scaled;
         STEP_FR_MR:  out_ff.mix_left       <= sat24(shr17);
         STEP_FR_S1L: out_ff.mix_right      <= sat24(shr17);
         STEP_FR_S1R: out_ff.send_one_left  <= sat24(prod_ff >>> 16);
         STEP_FR_S2L: out_ff.send_one_right <= sat24(prod_ff >>> 16);
         STEP_FR_S2R: out_ff.send_two_left  <= sat24(prod_ff >>> 16);
         STEP_FR_END: begin
            out_ff.send_two_right <= sat24(prod_ff >>> 16);
            out_ff.mute_lights    <= lights;
         end
         default: ;
      endcase
   end

   assign rsp_data = out_ff;

endmodule
